// File: rtl/core/cpbs_pkg.sv
package cpbs_pkg;

    localparam int ROWS_W    = 11;
    localparam int BLOCK_W   = 13;
    localparam int VERDICT_W = 3;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_REAPED   = 3'd0,
        VERDICT_REJECTED = 3'd1,
        VERDICT_FULL     = 3'd2,
        VERDICT_PARTIAL  = 3'd3,
        VERDICT_DEFERRED = 3'd4,
        VERDICT_PASSED   = 3'd5
    } verdict_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV1,
        ST_DIV2,
        ST_MUL,
        ST_OUT
    } state_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: rtl/core/cpbs_serdiv.sv
// restoring divider, one quotient bit per cycle
module cpbs_serdiv #(
    parameter int W   = 24,
    parameter int DVW = 13
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [W-1:0]              dividend,
    input  logic [DVW-1:0]            divisor,
    output logic [W-1:0]              quotient,
    output logic [DVW-1:0]            remainder,
    output cpbs_pkg::div_stat_t       stat
);

    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     qd_reg, qd_next;
    logic [DVW-1:0]   rem_reg, rem_next;
    logic [DVW-1:0]   dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVW:0]     shifted;
    logic [DVW:0]     diff;
    logic             fits;

    assign shifted = {rem_reg, qd_reg[W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        qd_next   = qd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            qd_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            qd_next  = {qd_reg[W-2:0], fits};
            rem_next = fits ? diff[DVW-1:0] : shifted[DVW-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qd_reg  <= qd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = qd_reg;
    assign remainder   = rem_reg;
    assign stat.busy   = busy_reg;
    assign stat.done   = done_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("divider done without a running division");

    a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && dvs_reg != '0) |-> (rem_reg < dvs_reg))
        else $error("divider remainder not below divisor");

endmodule

// File: rtl/core/chunked_prefill_budget_selector_unit.sv
// channel   | dir | signals                                   | contents
// ----------+-----+-------------------------------------------+------------------------------------
// request   | in  | s_tvalid s_tready s_tdata s_tuser         | one waiting request per transaction
// verdict   | out | m_tvalid m_tready m_tdata m_tuser m_tlast | one verdict per request
// config    | in  | cfg_wr_en cfg_wr_data                     | chunk token budget, no read-back
//
// paths: verdicts that need no division are registered at the acceptance edge; zero rows or
//   a misaligned reuse length take one divider pass over DW bits, DW the wider of the two
//   widths; a grant takes up to two divider passes and then the shift-add over the rows bits
// one request in flight at a time; the verdict waits in an output register
// reset clears the budget register, the round state and the output valid
// m_tready low holds the verdict and blocks the next acceptance only when it still waits
module chunked_prefill_budget_selector_unit #(
    parameter int MAX_SEQ_BITS = 20,
    parameter int BUDGET_BITS  = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [BUDGET_BITS-1:0]       cfg_wr_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // rows, reuse_len, seq_len, block_len, zero pad
    input  logic [((cpbs_pkg::ROWS_W + 2 * MAX_SEQ_BITS + cpbs_pkg::BLOCK_W + 7) / 8) * 8 - 1:0]
                                         s_tdata,
    // round_start, error_or_done
    input  logic [1:0]                   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // grant_len, zero pad
    output logic [((MAX_SEQ_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // verdict
    output logic [cpbs_pkg::VERDICT_W-1:0] m_tuser,
    // round_closed
    output logic                         m_tlast
);

    localparam int M_TDATA_W    = ((MAX_SEQ_BITS + 7) / 8) * 8;
    // shared divider width covers both budget and sequence values
    localparam int DW = (MAX_SEQ_BITS > BUDGET_BITS) ? MAX_SEQ_BITS : BUDGET_BITS;
    localparam int RW = cpbs_pkg::ROWS_W;
    localparam int KW = cpbs_pkg::BLOCK_W;
    localparam int S  = MAX_SEQ_BITS;
    localparam int B  = BUDGET_BITS;

    // request fields
    logic [RW-1:0] in_rows;
    logic [S-1:0]  in_reuse;
    logic [S-1:0]  in_seq;
    logic [KW-1:0] in_block;
    logic          in_round_start;
    logic          in_err;

    assign in_rows        = s_tdata[RW-1:0];
    assign in_reuse       = s_tdata[RW +: S];
    assign in_seq         = s_tdata[RW + S +: S];
    assign in_block       = s_tdata[RW + 2 * S +: KW];
    assign in_round_start = s_tuser[0];
    assign in_err         = s_tuser[1];

    // control and round state
    cpbs_pkg::state_t   state_reg, state_next;
    logic [B-1:0]       cfg_reg;
    logic [B-1:0]       tokens_left_reg, tokens_left_next;
    logic               any_sel_reg, any_sel_next;
    logic               closed_reg, closed_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // per-request working registers
    logic [RW-1:0]      rows_reg, rows_next;
    logic [S-1:0]       remain_reg, remain_next;
    logic [KW-1:0]      block_reg, block_next;
    logic [DW-1:0]      maxlen_reg, maxlen_next;
    logic [DW-1:0]      mcand_reg, mcand_next;
    logic [RW-1:0]      rows_sh_reg, rows_sh_next;
    cpbs_pkg::verdict_t verdict_reg, verdict_next;
    logic [S-1:0]       grant_reg, grant_next;

    // output register
    cpbs_pkg::verdict_t m_verdict_reg, m_verdict_next;
    logic [S-1:0]       m_grant_reg, m_grant_next;
    logic               m_closed_reg, m_closed_next;

    // dividers: a does the block remainders, b does budget / rows
    logic                div_a_start, div_b_start;
    logic [DW-1:0]       div_a_dvd, div_b_dvd;
    logic [KW-1:0]       div_a_dvs, div_b_dvs;
    logic [DW-1:0]       quo_a, quo_b;
    logic [KW-1:0]       rem_a, rem_b;
    cpbs_pkg::div_stat_t stat_a, stat_b;

    cpbs_serdiv #(.W(DW), .DVW(KW)) u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_a_start),
        .dividend  (div_a_dvd),
        .divisor   (div_a_dvs),
        .quotient  (quo_a),
        .remainder (rem_a),
        .stat      (stat_a)
    );

    cpbs_serdiv #(.W(DW), .DVW(KW)) u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_b_start),
        .dividend  (div_b_dvd),
        .divisor   (div_b_dvs),
        .quotient  (quo_b),
        .remainder (rem_b),
        .stat      (stat_b)
    );

    logic          out_free;
    logic          accept;
    logic [B-1:0]  cur_budget;
    logic          cur_closed;
    logic          cur_any;
    logic [DW-1:0] aligned;
    logic          stall_b;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == cpbs_pkg::ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign aligned  = maxlen_reg - DW'(rem_a);
    // b runs in lockstep with a; it is only read when a reports done
    assign stall_b  = stat_b.busy && !stat_a.busy;

    always_comb
    begin
        state_next       = state_reg;
        tokens_left_next = tokens_left_reg;
        any_sel_next     = any_sel_reg;
        closed_next      = closed_reg;
        rows_next        = rows_reg;
        remain_next      = remain_reg;
        block_next       = block_reg;
        maxlen_next      = maxlen_reg;
        mcand_next       = mcand_reg;
        rows_sh_next     = rows_sh_reg;
        verdict_next     = verdict_reg;
        grant_next       = grant_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_verdict_next   = m_verdict_reg;
        m_grant_next     = m_grant_reg;
        m_closed_next    = m_closed_reg;
        div_a_start      = 1'b0;
        div_b_start      = 1'b0;
        div_a_dvd        = DW'(in_reuse);
        div_a_dvs        = in_block;
        div_b_dvd        = '0;
        div_b_dvs        = KW'(in_rows);
        cur_budget       = in_round_start ? cfg_reg : tokens_left_reg;
        cur_closed       = in_round_start ? 1'b0 : closed_reg;
        cur_any          = in_round_start ? 1'b0 : any_sel_reg;

        case (state_reg)
            cpbs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    tokens_left_next = cur_budget;
                    closed_next      = cur_closed;
                    any_sel_next     = cur_any;
                    rows_next        = in_rows;
                    remain_next      = in_seq - in_reuse;
                    block_next       = in_block;
                    m_grant_next     = '0;
                    m_closed_next    = cur_closed;
                    if (cfg_reg == '0)
                    begin
                        // chunking disabled
                        m_tvalid_next  = 1'b1;
                        m_verdict_next = cpbs_pkg::VERDICT_PASSED;
                        m_closed_next  = 1'b0;
                    end
                    else if (cur_closed)
                    begin
                        m_tvalid_next  = 1'b1;
                        m_verdict_next = cpbs_pkg::VERDICT_DEFERRED;
                    end
                    else if (in_err)
                    begin
                        m_tvalid_next  = 1'b1;
                        m_verdict_next = cpbs_pkg::VERDICT_REAPED;
                    end
                    else if (in_seq <= in_reuse || in_block == '0)
                    begin
                        m_tvalid_next  = 1'b1;
                        m_verdict_next = cpbs_pkg::VERDICT_REJECTED;
                    end
                    else
                    begin
                        // reuse alignment and budget / rows side by side
                        div_a_start = 1'b1;
                        div_b_start = 1'b1;
                        div_b_dvd   = DW'(cur_budget);
                        state_next  = cpbs_pkg::ST_DIV1;
                    end
                end
            end

            cpbs_pkg::ST_DIV1:
            begin
                if (stat_a.done)
                begin
                    if (rem_a != '0)
                    begin
                        verdict_next = cpbs_pkg::VERDICT_REJECTED;
                        grant_next   = '0;
                        state_next   = cpbs_pkg::ST_OUT;
                    end
                    else if (rows_reg == '0)
                    begin
                        // zero grant
                        verdict_next = any_sel_reg ? cpbs_pkg::VERDICT_DEFERRED
                                                   : cpbs_pkg::VERDICT_REJECTED;
                        closed_next  = closed_reg || any_sel_reg;
                        grant_next   = '0;
                        state_next   = cpbs_pkg::ST_OUT;
                    end
                    else if (DW'(remain_reg) <= quo_b)
                    begin
                        verdict_next = cpbs_pkg::VERDICT_FULL;
                        grant_next   = remain_reg;
                        mcand_next   = DW'(remain_reg);
                        rows_sh_next = rows_reg;
                        state_next   = cpbs_pkg::ST_MUL;
                    end
                    else
                    begin
                        // round max_len down to a block multiple
                        maxlen_next = quo_b;
                        div_a_start = 1'b1;
                        div_a_dvd   = quo_b;
                        div_a_dvs   = block_reg;
                        state_next  = cpbs_pkg::ST_DIV2;
                    end
                end
            end

            cpbs_pkg::ST_DIV2:
            begin
                if (stat_a.done)
                begin
                    if (aligned == '0)
                    begin
                        verdict_next = any_sel_reg ? cpbs_pkg::VERDICT_DEFERRED
                                                   : cpbs_pkg::VERDICT_REJECTED;
                        closed_next  = closed_reg || any_sel_reg;
                        grant_next   = '0;
                        state_next   = cpbs_pkg::ST_OUT;
                    end
                    else
                    begin
                        verdict_next = cpbs_pkg::VERDICT_PARTIAL;
                        closed_next  = 1'b1;
                        grant_next   = S'(aligned);
                        mcand_next   = aligned;
                        rows_sh_next = rows_reg;
                        state_next   = cpbs_pkg::ST_MUL;
                    end
                end
            end

            cpbs_pkg::ST_MUL:
            begin
                // shift-add: take grant * rows off the budget, one rows bit per cycle
                if (rows_sh_reg == '0)
                begin
                    any_sel_next = 1'b1;
                    state_next   = cpbs_pkg::ST_OUT;
                end
                else
                begin
                    if (rows_sh_reg[0])
                    begin
                        tokens_left_next = tokens_left_reg - B'(mcand_reg);
                    end
                    mcand_next   = {mcand_reg[DW-2:0], 1'b0};
                    rows_sh_next = {1'b0, rows_sh_reg[RW-1:1]};
                end
            end

            cpbs_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next  = 1'b1;
                    m_verdict_next = verdict_reg;
                    m_grant_next   = grant_reg;
                    m_closed_next  = closed_reg;
                    state_next     = cpbs_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = cpbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= cpbs_pkg::ST_IDLE;
            cfg_reg         <= '0;
            tokens_left_reg <= '0;
            any_sel_reg     <= 1'b0;
            closed_reg      <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            tokens_left_reg <= tokens_left_next;
            any_sel_reg     <= any_sel_next;
            closed_reg      <= closed_next;
            m_tvalid_reg    <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rows_reg      <= rows_next;
        remain_reg    <= remain_next;
        block_reg     <= block_next;
        maxlen_reg    <= maxlen_next;
        mcand_reg     <= mcand_next;
        rows_sh_reg   <= rows_sh_next;
        verdict_reg   <= verdict_next;
        grant_reg     <= grant_next;
        m_verdict_reg <= m_verdict_next;
        m_grant_reg   <= m_grant_next;
        m_closed_reg  <= m_closed_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_grant_reg);
    assign m_tuser  = m_verdict_reg;
    assign m_tlast  = m_closed_reg;

    // both dividers start together for the first pass and finish together; a runs alone in ST_DIV2
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        !stall_b && (stat_a.done == stat_b.done || state_reg == cpbs_pkg::ST_DIV2
                     || $past(state_reg) == cpbs_pkg::ST_DIV2))
        else $error("budget divider out of step with block divider");

    // while chunking is enabled, a closed round defers every later request of that round
    a_closed_defers: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_round_start && closed_reg && cfg_reg != '0)
        |=> (m_tvalid && m_verdict_reg == cpbs_pkg::VERDICT_DEFERRED && m_tlast))
        else $error("request after round close not deferred");

    // only grants carry a length
    a_grant_only_on_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_grant_reg != '0)
        |-> (m_verdict_reg == cpbs_pkg::VERDICT_FULL
             || m_verdict_reg == cpbs_pkg::VERDICT_PARTIAL))
        else $error("nonzero grant length without a grant verdict");

    // the budget update never adds tokens
    a_budget_down: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cpbs_pkg::ST_MUL) |=> (tokens_left_reg <= $past(tokens_left_reg)))
        else $error("budget grew while charging a grant");

    // budget / rows leaves less than one row share over
    a_rows_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (stat_b.done && rows_reg != '0) |-> (rem_b < KW'(rows_reg)))
        else $error("budget remainder not below rows");

    // the block division splits max_len exactly
    a_align_split: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cpbs_pkg::ST_DIV2 && stat_a.done)
        |-> (quo_a * DW'(block_reg) + DW'(rem_a) == maxlen_reg))
        else $error("block split does not rebuild max_len");

endmodule
